### hdl/stbeq_pkg.sv
// Shared types and constants for the stereo three-band biquad equalizer.
package stbeq_pkg;

  // Fixed field widths of the beat formats
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int SLOT_W   = 4;
  localparam int MODE_W   = 2;

  // Sequencer counter widths, sized for the largest supported stage count (8)
  localparam int STAGE_W = 3;
  localparam int STEP_W  = 3;

  // Beat modes; the fourth code is unused and is dropped
  typedef enum logic [MODE_W-1:0] {
    MODE_FRAME = 2'd0,
    MODE_COEF  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Coefficient order inside one band, also the MAC step number
  localparam logic [STEP_W-1:0] TAP_B0 = 3'd0;
  localparam logic [STEP_W-1:0] TAP_B1 = 3'd1;
  localparam logic [STEP_W-1:0] TAP_B2 = 3'd2;
  localparam logic [STEP_W-1:0] TAP_A1 = 3'd3;
  localparam logic [STEP_W-1:0] TAP_A2 = 3'd4;
  // Step at which the accumulated sum is final and is written back
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [SLOT_W-1:0]          coef_slot;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_beat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic               in_take;
    logic               coef_we;
    logic               hist_clr;
    logic               issue;
    logic               acc_init;
    logic               finish;
    logic               load_out;
    logic               ch;
    logic [STAGE_W-1:0] stage;
    logic [STEP_W-1:0]  step;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/stbeq_dp.sv
// Datapath: coefficient and history memories, shared MAC, saturation, output register.
module stbeq_dp #(
  parameter int NUM_STAGES     = 3,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stbeq_pkg::dp_cmd_t   cmd_i,
  output stbeq_pkg::dp_stat_t  stat_o,
  input  stbeq_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stbeq_pkg::out_beat_t out_beat_o
);
  import stbeq_pkg::*;

  localparam int NCOEF = 5 * NUM_STAGES;
  localparam int NROW  = 2 * NUM_STAGES;
  localparam int CA_W  = $clog2(NCOEF);
  localparam int RA_W  = $clog2(NROW);
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE =
    (COEF_FRAC_BITS >= COEF_W - 1) ? COEF_MAX : (COEF_W'(1) << COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // History row: x1, x2, y1, y2
  typedef logic [3:0][SAMPLE_W-1:0] hist_row_t;

  logic signed [COEF_W-1:0]   coef_mem [NCOEF];
  logic [NCOEF-1:0]           coef_vld_q;
  hist_row_t                  hist_mem [NROW];
  logic [NROW-1:0]            hist_vld_q;

  logic                       slot_ok;
  logic [CA_W-1:0]            coef_wa;
  logic [CA_W-1:0]            coef_ra;
  logic [RA_W-1:0]            row_a;

  logic signed [COEF_W-1:0]   coef_rd_q;
  logic                       coef_rdv_q;
  logic [STEP_W-1:0]          kind_q;
  logic                       issue_q;
  hist_row_t                  row_q;
  logic                       row_vld_q;
  hist_row_t                  row_eff;

  logic signed [SAMPLE_W-1:0] samp_q [2];
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [COEF_W-1:0]   coef_eff;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       neg_q;
  logic                       mul_vld_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_shr;
  logic signed [SAMPLE_W-1:0] y_sat;
  hist_row_t                  new_row;

  logic                       out_valid_q;
  out_beat_t                  out_q;

  // Address decode
  assign slot_ok = 32'(in_beat_i.coef_slot) < 32'(NCOEF);
  assign coef_wa = CA_W'(in_beat_i.coef_slot);
  assign coef_ra = CA_W'(6'(cmd_i.stage) * 6'd5 + 6'(cmd_i.step));
  assign row_a   = RA_W'(4'(cmd_i.stage) + (cmd_i.ch ? 4'(NUM_STAGES) : 4'd0));

  // Coefficient store, never-written entries read as the pass-through reset value
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we && slot_ok) begin
      coef_mem[coef_wa] <= in_beat_i.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (cmd_i.coef_we && slot_ok) begin
      coef_vld_q[coef_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      coef_rd_q  <= coef_mem[coef_ra];
      coef_rdv_q <= coef_vld_q[coef_ra];
      kind_q     <= cmd_i.step;
    end
  end

  // History rows, one per channel and band
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hist_mem[row_a] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (cmd_i.hist_clr) begin
      hist_vld_q <= '0;
    end else if (cmd_i.finish) begin
      hist_vld_q[row_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= hist_mem[row_a];
    row_vld_q <= hist_vld_q[row_a];
  end

  assign row_eff = row_vld_q ? row_q : '0;
  assign x_cur   = samp_q[cmd_i.ch];

  // Select coefficient and operand for the current tap
  always_comb begin
    coef_eff = coef_rdv_q ? coef_rd_q : ((kind_q == TAP_B0) ? COEF_ONE : '0);
    case (kind_q)
      TAP_B0:  operand = x_cur;
      TAP_B1:  operand = row_eff[0];
      TAP_B2:  operand = row_eff[1];
      TAP_A1:  operand = row_eff[2];
      TAP_A2:  operand = row_eff[3];
      default: operand = '0;
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= coef_eff * operand;
    neg_q  <= (kind_q == TAP_A1) || (kind_q == TAP_A2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      issue_q   <= cmd_i.issue;
      mul_vld_q <= issue_q;
    end
  end

  // Accumulate; feedback taps subtract
  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      acc_q <= ROUND;
    end else if (mul_vld_q) begin
      acc_q <= neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  // Drop fraction bits and saturate to the sample range
  always_comb begin
    acc_shr = acc_q >>> COEF_FRAC_BITS;
    if ((&acc_shr[ACC_W-1:SAMPLE_W-1]) || !(|acc_shr[ACC_W-1:SAMPLE_W-1])) begin
      y_sat = acc_shr[SAMPLE_W-1:0];
    end else begin
      y_sat = acc_shr[ACC_W-1] ? SMIN : SMAX;
    end
    new_row[0] = x_cur;
    new_row[1] = row_eff[0];
    new_row[2] = y_sat;
    new_row[3] = row_eff[2];
  end

  // Working samples: frame input, then each band's output
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      samp_q[0] <= in_beat_i.left_in;
      samp_q[1] <= in_beat_i.right_in;
    end else if (cmd_i.finish) begin
      samp_q[cmd_i.ch] <= y_sat;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.left_out  <= samp_q[0];
      out_q.right_out <= samp_q[1];
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_beat_o      = out_q;

endmodule

### hdl/stbeq_ctrl.sv
// Controller: sequences bands, channels and MAC steps for one frame, and issues coefficient writes and history clears.
module stbeq_ctrl #(
  parameter int NUM_STAGES = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [stbeq_pkg::MODE_W-1:0] mode_i,
  input  stbeq_pkg::dp_stat_t     stat_i,
  output stbeq_pkg::dp_cmd_t      cmd_o
);
  import stbeq_pkg::*;

  localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(NUM_STAGES - 1);

  ctl_state_e         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic               ch_q, ch_d;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      stage_q <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      stage_q <= stage_d;
      ch_q    <= ch_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    stage_d        = stage_q;
    ch_d           = ch_q;
    cmd_o          = '0;
    cmd_o.ch       = ch_q;
    cmd_o.stage    = stage_q;
    cmd_o.step     = step_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_FRAME: begin
              cmd_o.in_take = 1'b1;
              state_d       = ST_RUN;
              step_d        = '0;
              stage_d       = '0;
              ch_d          = 1'b0;
            end
            MODE_COEF:  cmd_o.coef_we  = 1'b1;
            MODE_CLEAR: cmd_o.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end

      ST_RUN: begin
        cmd_o.issue    = (step_q <= TAP_A2);
        cmd_o.acc_init = (step_q == TAP_B0);
        cmd_o.finish   = (step_q == STEP_LAST);
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          step_d = '0;
          if (ch_q) begin
            ch_d = 1'b0;
            if (stage_q == STAGE_LAST) begin
              state_d = ST_DONE;
            end else begin
              stage_d = stage_q + 1'b1;
            end
          end else begin
            ch_d = 1'b1;
          end
        end
      end

      ST_DONE: begin
        // Hold the result until the output register can take it
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/stereo_three_band_biquad_eq.sv
// Top level of the stereo three-band biquad equalizer.
//
// Input channel: in_valid_i / in_stall_o / in_beat_i. Mode FRAME carries a stereo
// sample pair, mode COEF writes one coefficient (band*5 + b0,b1,b2,a1,a2), mode
// CLEAR zeroes all filter histories. COEF, CLEAR and the unused mode do not stall
// the input and produce no output beat.
// A frame runs NUM_STAGES direct-form-1 biquads per channel on one shared MAC:
// each biquad passes five taps through coefficient read, multiply and accumulate
// stages, then saturates and writes back its history. The input stalls from the
// accept of a frame until its output beat is loaded into the result register,
// which shows it on out_valid_o / out_beat_o.
// Output channel: a result register holds the beat while out_stall_i is high;
// new items are taken meanwhile, and a following frame waits at its end until
// the register is free.
// Reset: coefficients return to pass-through (b0 = 1.0, or the largest code if
// 1.0 does not fit), histories read as zero, no output beat pending.
module stereo_three_band_biquad_eq #(
  parameter int NUM_STAGES     = 3,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  stbeq_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output stbeq_pkg::out_beat_t out_beat_o
);
  import stbeq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stbeq_ctrl #(
    .NUM_STAGES (NUM_STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (in_beat_i.mode),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stbeq_dp #(
    .NUM_STAGES     (NUM_STAGES),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

### hdl/stbeq_chk.sv
// Port-level checker for the equalizer, bound to the top level.
module stbeq_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input stbeq_pkg::in_beat_t  in_beat_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input stbeq_pkg::out_beat_t out_beat_o
);
  import stbeq_pkg::*;

  logic in_beat_acc;
  logic frame_acc;

  assign in_beat_acc = in_valid_i && !in_stall_o;
  assign frame_acc   = in_beat_acc && (in_beat_i.mode == MODE_FRAME);

  // A stalled output beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)))
    else $error("output beat changed while stalled");

  // A frame occupies the MAC: no new beat the next cycle
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_acc |=> in_stall_o)
    else $error("beat taken right after a frame");

  // Coefficient writes, clears and unused modes leave the input unstalled the next cycle
  a_ctl_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat_acc && (in_beat_i.mode != MODE_FRAME)) |=> !in_stall_o)
    else $error("non-frame beat held the input");

  // A fresh output beat only appears at the end of frame processing
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat without frame processing");

endmodule

bind stereo_three_band_biquad_eq stbeq_chk u_stbeq_chk (.*);

### tb/eq_scoreboard_pkg.sv
// Scoreboard for the stereo three-band equalizer: filter predictor and output check.
`timescale 1ns / 1ps

package eq_scoreboard_pkg;
  import stbeq_pkg::*;

  class eq_scoreboard #(int BANDS = 3, int FRAC = 20);
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    localparam int     NUM_COEF  = 5 * BANDS;
    localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

    // Shared coefficients and per-channel, per-band history
    coef_t   coefs[NUM_COEF];
    sample_t hist_x1[2][BANDS];
    sample_t hist_x2[2][BANDS];
    sample_t hist_y1[2][BANDS];
    sample_t hist_y2[2][BANDS];

    // Equalized frames still owed by the block, oldest first
    out_beat_t eq_frames_due[$];

    int errors;
    int n_frames;
    int n_coef;
    int n_slot_dropped;
    int n_clear;
    int n_unused;
    int n_checked;
    int n_sat;

    function new();
      longint unity;
      longint coef_hi;
      unity   = longint'(1) <<< FRAC;
      coef_hi = (longint'(1) <<< (COEF_W - 1)) - 1;
      // Fall back to the largest code when 1.0 does not fit
      if (unity > coef_hi) unity = coef_hi;
      foreach (coefs[i]) coefs[i] = (i % 5 == TAP_B0) ? COEF_W'(unity) : '0;
      clear_history();
    endfunction

    function void clear_history();
      foreach (hist_x1[c, s]) begin
        hist_x1[c][s] = '0;
        hist_x2[c][s] = '0;
        hist_y1[c][s] = '0;
        hist_y2[c][s] = '0;
      end
    endfunction

    // One direct-form-1 section: exact sum, round half up, saturate, shift history
    function sample_t run_band(int ch, int band, sample_t x);
      longint acc;
      int     base;
      base = 5 * band;
      acc = longint'(coefs[base + TAP_B0]) * longint'(x)
          + longint'(coefs[base + TAP_B1]) * longint'(hist_x1[ch][band])
          + longint'(coefs[base + TAP_B2]) * longint'(hist_x2[ch][band])
          - longint'(coefs[base + TAP_A1]) * longint'(hist_y1[ch][band])
          - longint'(coefs[base + TAP_A2]) * longint'(hist_y2[ch][band])
          + (longint'(1) <<< (FRAC - 1));
      acc = acc >>> FRAC;
      if (acc > SAMPLE_HI) begin
        acc = SAMPLE_HI;
        n_sat++;
      end else if (acc < SAMPLE_LO) begin
        acc = SAMPLE_LO;
        n_sat++;
      end
      hist_x2[ch][band] = hist_x1[ch][band];
      hist_x1[ch][band] = x;
      hist_y2[ch][band] = hist_y1[ch][band];
      hist_y1[ch][band] = sample_t'(acc);
      return sample_t'(acc);
    endfunction

    // Apply an accepted input beat to the predicted state
    function void note_input(in_beat_t b);
      sample_t   l;
      sample_t   r;
      out_beat_t want;
      case (b.mode)
        MODE_FRAME: begin
          l = b.left_in;
          r = b.right_in;
          for (int s = 0; s < BANDS; s++) begin
            l = run_band(0, s, l);
            r = run_band(1, s, r);
          end
          want.left_out  = l;
          want.right_out = r;
          eq_frames_due.push_back(want);
          n_frames++;
        end
        MODE_COEF: begin
          n_coef++;
          if (b.coef_slot < NUM_COEF) coefs[b.coef_slot] = b.coef_value;
          else n_slot_dropped++;
        end
        MODE_CLEAR: begin
          clear_history();
          n_clear++;
        end
        default: n_unused++;
      endcase
    endfunction

    // Compare an accepted output beat with the oldest prediction
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (eq_frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, expected none, actual left %0d right %0d",
                 $time, got.left_out, got.right_out);
        return;
      end
      want = eq_frames_due.pop_front();
      n_checked++;
      if (got.left_out !== want.left_out) begin
        errors++;
        $display("%0t: left_out mismatch, expected %0d actual %0d",
                 $time, want.left_out, got.left_out);
      end
      if (got.right_out !== want.right_out) begin
        errors++;
        $display("%0t: right_out mismatch, expected %0d actual %0d",
                 $time, want.right_out, got.right_out);
      end
    endfunction

    function int pending();
      return eq_frames_due.size();
    endfunction
  endclass

endpackage

### tb/stereo_three_band_biquad_eq_test.sv
// Testbench top for the stereo three-band biquad equalizer.
`timescale 1ns / 1ps

module stereo_three_band_biquad_eq_test;
  import stbeq_pkg::*;
  import eq_scoreboard_pkg::*;

  localparam int BANDS     = 3;
  localparam int FRAC      = 20;
  localparam int NUM_COEF  = 5 * BANDS;
  localparam int LATENCY   = 16 * BANDS + 2;
  localparam int LONG_HOLD = 400;
  localparam int PHASES    = 7;

  localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(1 << FRAC);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // Idling switches for each side, and a request for one long receiver hold
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  bit rx_hold_req = 1'b0;

  eq_scoreboard #(BANDS, FRAC) sb;

  stereo_three_band_biquad_eq #(
    .NUM_STAGES     (BANDS),
    .COEF_FRAC_BITS (FRAC)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #5 clk = ~clk;

  // Check every output beat taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_beat);
  end

  // Receiver: stall a random count before each beat, or hold off long on request
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = rx_idle ? $urandom_range(0, 19) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  // Beat with every field random; callers override what matters
  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.mode       = MODE_W'($urandom_range(0, 3));
    b.coef_slot  = SLOT_W'($urandom_range(0, 15));
    b.coef_value = COEF_W'($urandom);
    b.left_in    = SAMPLE_W'($urandom);
    b.right_in   = SAMPLE_W'($urandom);
    return b;
  endfunction

  // Mix full-scale, quiet and extreme samples
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] s;
    s = SAMPLE_W'($urandom);
    case ($urandom_range(0, 5))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2, 3:    s = s >>> $urandom_range(4, 16);
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l, r);
    in_beat_t b;
    b          = random_beat();
    b.mode     = MODE_FRAME;
    b.left_in  = l;
    b.right_in = r;
    send_beat(b);
  endtask

  task automatic send_coef(input logic [SLOT_W-1:0] slot, input logic signed [COEF_W-1:0] v);
    in_beat_t b;
    b            = random_beat();
    b.mode       = MODE_COEF;
    b.coef_slot  = slot;
    b.coef_value = v;
    send_beat(b);
  endtask

  task automatic send_mode(input logic [MODE_W-1:0] m);
    in_beat_t b;
    b      = random_beat();
    b.mode = m;
    send_beat(b);
  endtask

  // Load all bands: shaped filters, or raw full-range codes
  task automatic load_coef_set(input bit full_range);
    int span;
    int v;
    for (int slot = 0; slot < NUM_COEF; slot++) begin
      if (slot % 5 == TAP_A1)      span = 1992294;
      else if (slot % 5 == TAP_A2) span = 996147;
      else                         span = 2 << FRAC;
      v = int'($urandom_range(0, 2 * span)) - span;
      send_coef(SLOT_W'(slot), full_range ? COEF_W'($urandom) : COEF_W'(v));
    end
  endtask

  // Drop valid and wait until every predicted frame has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Main stimulus
  initial begin
    int pick;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass-through after reset, extremes both ways
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame('0, -1);
    // Unused mode and an out-of-range slot must change nothing
    send_mode(MODE_UNUSED);
    send_coef(SLOT_W'(NUM_COEF), COEF_MIN);
    send_frame(1, -2);
    // Largest gains in either sign force saturation
    send_coef(SLOT_W'(0), COEF_MAX);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_coef(SLOT_W'(0), COEF_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    // Feedback in the first band and the last slot, from clean history
    send_mode(MODE_CLEAR);
    send_coef(SLOT_W'(0), COEF_ONE);
    send_coef(SLOT_W'(1), COEF_ONE >>> 1);
    send_coef(SLOT_W'(2), -(COEF_ONE >>> 2));
    send_coef(SLOT_W'(3), -(COEF_ONE >>> 1));
    send_coef(SLOT_W'(4), COEF_ONE >>> 2);
    send_coef(SLOT_W'(NUM_COEF - 1), -(COEF_ONE >>> 3));
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(12345, -12345);
    send_frame('0, '0);
    send_mode(MODE_CLEAR);
    send_frame('0, '0);
    drain();

    // Random phases: a coefficient set, then mostly frames with some noise
    for (int p = 0; p < PHASES; p++) begin
      tx_idle = (p != 1);
      rx_idle = (p != 1) && (p != 4);
      if (p == 2) rx_hold_req = 1'b1;
      load_coef_set(p % 3 == 0);
      if ($urandom_range(0, 1)) send_mode(MODE_CLEAR);
      repeat (55) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)      send_frame(random_sample(), random_sample());
        else if (pick < 91) send_coef(SLOT_W'($urandom_range(0, 15)), COEF_W'($urandom));
        else if (pick < 96) send_mode(MODE_CLEAR);
        else                send_mode(MODE_UNUSED);
      end
      drain();
    end

    // Let any stray beat show up before judging
    repeat (2 * LATENCY) @(posedge clk);
    $display("Covered %0d frames, %0d coef writes (%0d bad slots), %0d clears, %0d unused modes.",
             sb.n_frames, sb.n_coef, sb.n_slot_dropped, sb.n_clear, sb.n_unused);
    $display("Checked %0d output beats; %0d band outputs saturated; %0d mismatches.",
             sb.n_checked, sb.n_sat, sb.errors);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Timeout
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
